// ----- rtl/pixel_fixed_radius_neighbor_table_unit_defines.svh -----
// Assertion macros for the pixel fixed radius neighbor table unit.
`ifndef PIXEL_FIXED_RADIUS_NEIGHBOR_TABLE_UNIT_DEFINES_SVH
`define PIXEL_FIXED_RADIUS_NEIGHBOR_TABLE_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PFRN_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PFRN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pfrn_pkg.sv -----
// Package with the types and constants of the pixel fixed radius neighbor table unit.
package pfrn_pkg;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_LOAD   = 2'd1,
      MODE_APPEND = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_HEADER   = 2'd0,
      KIND_NEIGHBOR = 2'd1,
      KIND_PADDING  = 2'd2,
      KIND_SINGLE   = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_RADIUS_SQ    = 1'b0,
      CSR_CENTER_LIMIT = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_CENTER,
      ST_SCAN,
      ST_DRAIN,
      ST_HEAD,
      ST_LREAD,
      ST_LOUT,
      ST_SINGLE
   } state_type;

   localparam int MIN_LISTED = 6;
   localparam logic [32:0] RADIUS_SQ_RESET = 33'd629801;
   localparam logic [14:0] CENTER_LIMIT_RESET = 15'd25600;

   typedef struct packed {
      logic        excluded;
      logic [7:0]  cluster;
      logic [11:0] channel;
      logic [15:0] x;
      logic [15:0] y;
   } pixel_type;

   typedef struct packed {
      logic [7:0]  cluster;
      logic [11:0] channel;
   } nbr_type;

   typedef logic [13:0] xkey_type;

endpackage

// ----- rtl/pixel_fixed_radius_neighbor_table_unit.sv -----
// Pixel map with exclusion table and fixed radius neighbor search.
//
// Clear and exclusion loads are done in the idle state; an append then writes the
// pixel in the append state. A query whose index lies past the fill count answers
// straight from idle; a query of an excluded pixel or of a pixel outside the center
// limit passes the center state first, since the pixel is read first. Both answer with
// one word. A query of a center pixel streams the whole pixel memory through its single
// read port, one pixel per cycle, into a three stage distance pipeline, then sends a
// header and max(6, neighbor_count) list entries; each listed entry waits for the
// registered read of the neighbor buffer. The pixel memory has no reset and no clearing
// pass: only entries below the fill count are ever used. The next word is accepted as
// soon as the final result of a query sits in the output register.
`include "pixel_fixed_radius_neighbor_table_unit_defines.svh"

module pixel_fixed_radius_neighbor_table_unit #(
   parameter int MAX_PIXELS    = 1024,
   parameter int EXCLUDE_SLOTS = 32,
   parameter int MAX_NEIGHBORS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_index,
   input  logic [7:0]         req_cluster,
   input  logic [5:0]         req_chan_in_cluster,
   input  logic [11:0]        req_ext_channel,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [8:0]  rsp_out_cluster,
   output logic signed [12:0] rsp_out_channel,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic [3:0]         rsp_neighbor_count,
   output logic               rsp_truncated,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [32:0]        csr_data
);

   localparam int PA_W  = $clog2(MAX_PIXELS);
   localparam int PT_W  = $clog2(MAX_PIXELS + 1);
   localparam int QW    = (PT_W > 10) ? PT_W : 10;
   localparam int NB_AW = $clog2(MAX_NEIGHBORS);
   localparam int NB_CW = $clog2(MAX_NEIGHBORS + 1);

   pfrn_pkg::state_type state_ff, state_in;

   logic [32:0]            radius_sq_ff, radius_sq_in;
   logic [14:0]            center_limit_ff, center_limit_in;
   logic [PT_W-1:0]        pixel_total_ff, pixel_total_in;
   logic [EXCLUDE_SLOTS-1:0] xv_ff, xv_in;
   pfrn_pkg::xkey_type     xe_ff [EXCLUDE_SLOTS];
   pfrn_pkg::xkey_type     xe_in [EXCLUDE_SLOTS];
   logic [EXCLUDE_SLOTS-1:0] match_ff, match_in;
   pfrn_pkg::pixel_type    ap_ff, ap_in;
   logic [PA_W-1:0]        q_idx_ff, q_idx_in;
   pfrn_pkg::pixel_type    cen_ff, cen_in;
   logic [PT_W-1:0]        scan_ff, scan_in;

   logic                   rv_ff, rv_in;
   logic [PA_W-1:0]        rj_ff, rj_in;
   logic                   a_valid_ff, a_valid_in;
   logic                   a_use_ff, a_use_in;
   pfrn_pkg::nbr_type      a_nb_ff, a_nb_in;
   logic signed [16:0]     a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic                   b_valid_ff, b_valid_in;
   pfrn_pkg::nbr_type      b_nb_ff, b_nb_in;
   logic [33:0]            b_sqx_ff, b_sqx_in, b_sqy_ff, b_sqy_in;
   logic [NB_CW-1:0]       found_ff, found_in;
   logic                   trunc_ff, trunc_in;
   logic [NB_CW-1:0]       e_ff, e_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [8:0]             rsp_cluster_ff, rsp_cluster_in;
   logic [12:0]            rsp_channel_ff, rsp_channel_in;
   logic [15:0]            rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [3:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_trunc_ff, rsp_trunc_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_load;

   pfrn_pkg::pixel_type    pix_mem [MAX_PIXELS];
   pfrn_pkg::pixel_type    rd_data_ff;
   logic [PA_W-1:0]        rd_addr;
   logic                   pix_we;
   pfrn_pkg::pixel_type    pix_wdata;
   pfrn_pkg::nbr_type      nb_mem [MAX_NEIGHBORS];
   pfrn_pkg::nbr_type      nb_rd_ff;
   logic                   nb_we;

   logic                   accept;
   logic                   out_free;
   logic                   in_range;
   logic                   center_ok;
   logic                   scan_last;
   logic                   pipe_busy;
   logic                   hit;
   logic                   list_last;
   logic [NB_CW-1:0]       list_len;
   logic [NB_CW+3:0]       count_ext;
   logic signed [16:0]     lim_s, neg_lim_s, rx_s, ry_s, cx_s, cy_s;
   logic signed [33:0]     sqx_full, sqy_full;
   logic [34:0]            dist_sq;
   pfrn_pkg::xkey_type     req_key;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pfrn_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_key   = {req_cluster, req_chan_in_cluster};
   assign in_range  = QW'(req_index) < QW'(pixel_total_ff);

   assign lim_s     = $signed({2'b00, center_limit_ff});
   assign neg_lim_s = -lim_s;
   assign rx_s      = $signed({rd_data_ff.x[15], rd_data_ff.x});
   assign ry_s      = $signed({rd_data_ff.y[15], rd_data_ff.y});
   assign cx_s      = $signed({cen_ff.x[15], cen_ff.x});
   assign cy_s      = $signed({cen_ff.y[15], cen_ff.y});
   assign center_ok = !rd_data_ff.excluded && (rx_s > neg_lim_s) && (rx_s < lim_s) &&
                      (ry_s > neg_lim_s) && (ry_s < lim_s);

   assign scan_last = (scan_ff == pixel_total_ff - PT_W'(1));
   assign pipe_busy = rv_ff || a_valid_ff || b_valid_ff;

   assign sqx_full  = a_dx_ff * a_dx_ff;
   assign sqy_full  = a_dy_ff * a_dy_ff;
   assign dist_sq   = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign hit       = b_valid_ff && (dist_sq < {2'b00, radius_sq_ff});
   assign nb_we     = hit && (found_ff < NB_CW'(MAX_NEIGHBORS));

   assign list_len  = (found_ff < NB_CW'(pfrn_pkg::MIN_LISTED)) ?
                      NB_CW'(pfrn_pkg::MIN_LISTED) : found_ff;
   assign list_last = (e_ff == list_len - NB_CW'(1));
   assign count_ext = {4'b0000, found_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfrn_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (pfrn_pkg::mode_type'(req_mode))
                  pfrn_pkg::MODE_CLEAR:  state_in = pfrn_pkg::ST_IDLE;
                  pfrn_pkg::MODE_LOAD:   state_in = pfrn_pkg::ST_IDLE;
                  pfrn_pkg::MODE_APPEND: begin
                     if (pixel_total_ff < PT_W'(MAX_PIXELS)) begin
                        state_in = pfrn_pkg::ST_APPEND;
                     end
                  end
                  pfrn_pkg::MODE_QUERY: begin
                     state_in = in_range ? pfrn_pkg::ST_CENTER : pfrn_pkg::ST_SINGLE;
                  end
               endcase
            end
         end
         pfrn_pkg::ST_APPEND: state_in = pfrn_pkg::ST_IDLE;
         pfrn_pkg::ST_CENTER: begin
            state_in = center_ok ? pfrn_pkg::ST_SCAN : pfrn_pkg::ST_SINGLE;
         end
         pfrn_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = pfrn_pkg::ST_DRAIN;
            end
         end
         pfrn_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = pfrn_pkg::ST_HEAD;
            end
         end
         pfrn_pkg::ST_HEAD: begin
            if (out_free) begin
               state_in = pfrn_pkg::ST_LREAD;
            end
         end
         pfrn_pkg::ST_LREAD: state_in = pfrn_pkg::ST_LOUT;
         pfrn_pkg::ST_LOUT: begin
            if (out_free) begin
               state_in = list_last ? pfrn_pkg::ST_IDLE : pfrn_pkg::ST_LREAD;
            end
         end
         pfrn_pkg::ST_SINGLE: begin
            if (out_free) begin
               state_in = pfrn_pkg::ST_IDLE;
            end
         end
         default: state_in = pfrn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rd_addr          = PA_W'(req_index);
      pix_we           = 1'b0;
      pix_wdata        = ap_ff;
      pix_wdata.excluded = |match_ff;
      rsp_load         = 1'b0;
      rsp_kind_in      = rsp_kind_ff;
      rsp_cluster_in   = rsp_cluster_ff;
      rsp_channel_in   = rsp_channel_ff;
      rsp_x_in         = rsp_x_ff;
      rsp_y_in         = rsp_y_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_trunc_in     = rsp_trunc_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         pfrn_pkg::ST_APPEND: pix_we = 1'b1;
         pfrn_pkg::ST_SCAN:   rd_addr = PA_W'(scan_ff);
         pfrn_pkg::ST_HEAD: begin
            rsp_load       = out_free;
            rsp_kind_in    = pfrn_pkg::KIND_HEADER;
            rsp_cluster_in = {1'b0, cen_ff.cluster};
            rsp_channel_in = {1'b0, cen_ff.channel};
            rsp_x_in       = cen_ff.x;
            rsp_y_in       = cen_ff.y;
            rsp_count_in   = count_ext[3:0];
            rsp_trunc_in   = trunc_ff;
            rsp_last_in    = 1'b0;
         end
         pfrn_pkg::ST_LOUT: begin
            rsp_load     = out_free;
            rsp_x_in     = '0;
            rsp_y_in     = '0;
            rsp_count_in = '0;
            rsp_trunc_in = 1'b0;
            rsp_last_in  = list_last;
            if (e_ff < found_ff) begin
               rsp_kind_in    = pfrn_pkg::KIND_NEIGHBOR;
               rsp_cluster_in = {1'b0, nb_rd_ff.cluster};
               rsp_channel_in = {1'b0, nb_rd_ff.channel};
            end else begin
               rsp_kind_in    = pfrn_pkg::KIND_PADDING;
               rsp_cluster_in = '1;
               rsp_channel_in = '1;
            end
         end
         pfrn_pkg::ST_SINGLE: begin
            rsp_load       = out_free;
            rsp_kind_in    = pfrn_pkg::KIND_SINGLE;
            rsp_cluster_in = {1'b0, cen_ff.cluster};
            rsp_channel_in = {1'b0, cen_ff.channel};
            rsp_x_in       = '0;
            rsp_y_in       = '0;
            rsp_count_in   = '0;
            rsp_trunc_in   = 1'b0;
            rsp_last_in    = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall && rsp_valid_ff);
   end

   always_comb begin
      radius_sq_in    = radius_sq_ff;
      center_limit_in = center_limit_ff;
      pixel_total_in  = pixel_total_ff;
      xv_in           = xv_ff;
      xe_in           = xe_ff;
      match_in        = match_ff;
      ap_in           = ap_ff;
      q_idx_in        = q_idx_ff;
      cen_in          = cen_ff;
      scan_in         = scan_ff;
      found_in        = found_ff;
      trunc_in        = trunc_ff;
      e_in            = e_ff;

      if (csr_write) begin
         unique case (pfrn_pkg::csr_type'(csr_index))
            pfrn_pkg::CSR_RADIUS_SQ:    radius_sq_in = csr_data;
            pfrn_pkg::CSR_CENTER_LIMIT: center_limit_in = csr_data[14:0];
         endcase
      end

      rv_in      = (state_ff == pfrn_pkg::ST_SCAN);
      rj_in      = PA_W'(scan_ff);
      a_valid_in = rv_ff;
      a_use_in   = (rj_ff != q_idx_ff) && !rd_data_ff.excluded;
      a_nb_in    = '{cluster: rd_data_ff.cluster, channel: rd_data_ff.channel};
      a_dx_in    = cx_s - rx_s;
      a_dy_in    = cy_s - ry_s;
      b_valid_in = a_valid_ff && a_use_ff;
      b_nb_in    = a_nb_ff;
      b_sqx_in   = sqx_full;
      b_sqy_in   = sqy_full;

      if (nb_we) begin
         found_in = found_ff + NB_CW'(1);
      end else if (hit) begin
         trunc_in = 1'b1;
      end

      unique case (state_ff)
         pfrn_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (pfrn_pkg::mode_type'(req_mode))
                  pfrn_pkg::MODE_CLEAR: pixel_total_in = '0;
                  pfrn_pkg::MODE_LOAD: begin
                     for (int s = 0; s < EXCLUDE_SLOTS; s++) begin
                        if (req_index == 10'(s)) begin
                           xe_in[s] = req_key;
                           xv_in[s] = 1'b1;
                        end
                     end
                  end
                  pfrn_pkg::MODE_APPEND: begin
                     ap_in.excluded = 1'b0;
                     ap_in.cluster  = req_cluster;
                     ap_in.channel  = req_ext_channel;
                     ap_in.x        = req_pos_x;
                     ap_in.y        = req_pos_y;
                     for (int s = 0; s < EXCLUDE_SLOTS; s++) begin
                        match_in[s] = xv_ff[s] && (xe_ff[s] == req_key);
                     end
                  end
                  pfrn_pkg::MODE_QUERY: begin
                     q_idx_in = PA_W'(req_index);
                     cen_in   = '0;
                  end
               endcase
            end
         end
         pfrn_pkg::ST_APPEND: pixel_total_in = pixel_total_ff + PT_W'(1);
         pfrn_pkg::ST_CENTER: begin
            cen_in   = rd_data_ff;
            scan_in  = '0;
            found_in = '0;
            trunc_in = 1'b0;
         end
         pfrn_pkg::ST_SCAN:  scan_in = scan_ff + PT_W'(1);
         pfrn_pkg::ST_HEAD:  e_in = '0;
         pfrn_pkg::ST_LOUT: begin
            if (out_free) begin
               e_in = e_ff + NB_CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pfrn_pkg::ST_IDLE;
         radius_sq_ff    <= pfrn_pkg::RADIUS_SQ_RESET;
         center_limit_ff <= pfrn_pkg::CENTER_LIMIT_RESET;
         pixel_total_ff  <= '0;
         xv_ff           <= '0;
         rv_ff           <= 1'b0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         found_ff        <= '0;
         trunc_ff        <= 1'b0;
         e_ff            <= '0;
         scan_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         radius_sq_ff    <= radius_sq_in;
         center_limit_ff <= center_limit_in;
         pixel_total_ff  <= pixel_total_in;
         xv_ff           <= xv_in;
         rv_ff           <= rv_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         found_ff        <= found_in;
         trunc_ff        <= trunc_in;
         e_ff            <= e_in;
         scan_ff         <= scan_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // The output word is loaded only when the register is free, so a stalled word holds.
   always_ff @(posedge clock) begin
      xe_ff          <= xe_in;
      match_ff       <= match_in;
      ap_ff          <= ap_in;
      q_idx_ff       <= q_idx_in;
      cen_ff         <= cen_in;
      rj_ff          <= rj_in;
      a_use_ff       <= a_use_in;
      a_nb_ff        <= a_nb_in;
      a_dx_ff        <= a_dx_in;
      a_dy_ff        <= a_dy_in;
      b_nb_ff        <= b_nb_in;
      b_sqx_ff       <= b_sqx_in;
      b_sqy_ff       <= b_sqy_in;
      if (rsp_load) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_cluster_ff <= rsp_cluster_in;
         rsp_channel_ff <= rsp_channel_in;
         rsp_x_ff       <= rsp_x_in;
         rsp_y_ff       <= rsp_y_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_trunc_ff   <= rsp_trunc_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[PA_W'(pixel_total_ff)] <= pix_wdata;
      end
      rd_data_ff <= pix_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nb_we) begin
         nb_mem[found_ff[NB_AW-1:0]] <= b_nb_ff;
      end
      nb_rd_ff <= nb_mem[e_ff[NB_AW-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_out_cluster    = rsp_cluster_ff;
   assign rsp_out_channel    = rsp_channel_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_truncated      = rsp_trunc_ff;
   assign rsp_last           = rsp_last_ff;

   `PFRN_ASSERT(a_found_bound, 1'b1, found_ff <= NB_CW'(MAX_NEIGHBORS), "Neighbor count overran the buffer.")
   `PFRN_ASSERT(a_trunc_full, trunc_ff, found_ff == NB_CW'(MAX_NEIGHBORS), "Truncation flagged before the buffer was full.")
   `PFRN_ASSERT(a_head_drained, state_ff == pfrn_pkg::ST_HEAD, !pipe_busy, "Header sent while the distance pipeline still held pixels.")
   `PFRN_ASSERT_NEXT(a_append_count, state_ff == pfrn_pkg::ST_APPEND, pixel_total_ff == $past(pixel_total_ff) + PT_W'(1), "Append did not advance the pixel count.")

endmodule
